FILE: rtl/core/bba_pkg.sv
`default_nettype none
// ============================================================================
// bba_pkg
// Types, constants and helper functions of the first-fit block allocator.
// ============================================================================
package bba_pkg;

    localparam int NUM_BLOCKS      = 1024;
    localparam int WORD_BITS       = 32;
    localparam int RESERVED_BLOCKS = 64;

    localparam int BITMAP_WORDS    = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int RESERVED_CLAMP  = (RESERVED_BLOCKS > NUM_BLOCKS) ? NUM_BLOCKS
                                                                     : RESERVED_BLOCKS;
    localparam int ADDR_W          = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int BIT_W           = $clog2(WORD_BITS);
    localparam int IDX_W           = $clog2(BITMAP_WORDS * WORD_BITS + 1);

    localparam int ID_W            = 11;
    localparam int STATUS_W        = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic            command;
        logic [ID_W-1:0] target_id;
    } bba_req_t;

    typedef struct packed {
        logic [ID_W-1:0]     granted_id;
        logic [STATUS_W-1:0] status;
    } bba_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE
    } bba_state_t;

    // Power-up content of a bitmap word: reserved ids used, padding past
    // the last block used, everything else free.
    function automatic logic [WORD_BITS-1:0] reset_word(input logic [ADDR_W-1:0] addr);
        logic [WORD_BITS-1:0] w;
        int                   base;
        base = int'(addr) * WORD_BITS;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            w[b] = ((base + b) < RESERVED_CLAMP) || ((base + b) >= NUM_BLOCKS);
        end
        return w;
    endfunction

    // Index of the lowest clear bit; meaningless when the word is all ones.
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/block_bitmap_allocator.sv
`default_nettype none
// ============================================================================
// block_bitmap_allocator
// First-fit free-block allocator over a word-organized usage bitmap.
// ============================================================================
// Command interface: a transaction is taken when start is high and busy is
// low. Every transaction returns exactly one response, shown for a single
// cycle with done high; the receiver cannot stall it. A free of an
// out-of-range id answers in the cycle after acceptance. A free in range
// reads one bitmap word, then writes it back. An allocate reads the bitmap
// one word per cycle from the lowest word up and answers at the first word
// with a clear bit, or after the last word with STATUS_FULL when the bitmap
// is full. The bitmap RAM's single read port sets this pace. A new
// transaction can be taken in the cycle its predecessor's response is shown.
// No clearing pass is needed after reset: per-word valid flags make unwritten
// words read as their power-up content.
module block_bitmap_allocator (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bba_pkg::bba_req_t request,
    output logic                   done,
    output bba_pkg::bba_rsp_t      response
);
    import bba_pkg::*;

    bba_state_t state_reg;
    bba_state_t state_next;

    logic [ADDR_W-1:0]       addr_reg;
    logic [ADDR_W-1:0]       addr_next;
    logic [BIT_W-1:0]        bit_reg;
    logic [BIT_W-1:0]        bit_next;
    logic                    done_reg;
    logic                    done_next;
    bba_rsp_t                rsp_reg;
    bba_rsp_t                rsp_next;
    logic [BITMAP_WORDS-1:0] word_valid_reg;
    logic [BITMAP_WORDS-1:0] word_valid_next;

    logic [WORD_BITS-1:0] mem [BITMAP_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rinit_reg;

    logic                 accept;
    logic                 id_in_range;
    logic [ID_W-1:0]      free_idx;
    logic [WORD_BITS-1:0] cur_word;
    logic                 has_zero;
    logic [BIT_W-1:0]     zero_bit;
    logic [IDX_W-1:0]     alloc_id;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    assign busy        = (state_reg != ST_IDLE);
    assign accept      = start && !busy;
    assign id_in_range = (request.target_id != '0) && (32'(request.target_id) <= NUM_BLOCKS);
    assign free_idx    = request.target_id - ID_W'(1);
    assign cur_word    = rinit_reg ? rdata_reg : reset_word(addr_reg);
    assign has_zero    = !(&cur_word);
    assign zero_bit    = first_zero(cur_word);
    assign alloc_id    = IDX_W'(addr_reg) * IDX_W'(WORD_BITS) + IDX_W'(zero_bit) + IDX_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.command == CMD_ALLOC)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (id_in_range)
                    begin
                        state_next = ST_FREE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (has_zero || (addr_reg == ADDR_W'(BITMAP_WORDS - 1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FREE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        addr_next           = addr_reg;
        bit_next            = bit_reg;
        done_next           = 1'b0;
        rsp_next            = rsp_reg;
        wr_en               = 1'b0;
        wr_data             = cur_word;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.command == CMD_ALLOC)
                    begin
                        addr_next = '0;
                    end
                    else if (id_in_range)
                    begin
                        addr_next = ADDR_W'(free_idx / WORD_BITS);
                        bit_next  = BIT_W'(free_idx % WORD_BITS);
                    end
                    else
                    begin
                        done_next           = 1'b1;
                        rsp_next.granted_id = '0;
                        rsp_next.status     = STATUS_RANGE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (has_zero)
                begin
                    wr_en               = 1'b1;
                    wr_data             = cur_word | (WORD_BITS'(1) << zero_bit);
                    done_next           = 1'b1;
                    rsp_next.granted_id = ID_W'(alloc_id);
                    rsp_next.status     = STATUS_OK;
                end
                else if (addr_reg == ADDR_W'(BITMAP_WORDS - 1))
                begin
                    done_next           = 1'b1;
                    rsp_next.granted_id = '0;
                    rsp_next.status     = STATUS_FULL;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_FREE:
            begin
                wr_en               = 1'b1;
                wr_data             = cur_word & ~(WORD_BITS'(1) << bit_reg);
                done_next           = 1'b1;
                rsp_next.granted_id = '0;
                rsp_next.status     = STATUS_OK;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
        word_valid_next = word_valid_reg |
                          (wr_en ? (BITMAP_WORDS'(1) << addr_reg) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            word_valid_reg <= '0;
            rinit_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            word_valid_reg <= word_valid_next;
            rinit_reg      <= word_valid_next[addr_next];
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        bit_reg  <= bit_next;
        rsp_reg  <= rsp_next;
    end

    // bitmap RAM, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wr_data;
        end
        rdata_reg <= mem[addr_next];
    end

    assign done     = done_reg;
    assign response = rsp_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response shown while still busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("accepted transaction neither in progress nor answered");

    a_fail_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (response.status != STATUS_OK)) |-> (response.granted_id == '0))
        else $error("error response carries a nonzero id");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (busy && done_next))
        else $error("bitmap write outside a finishing transaction");

    a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (32'(addr_reg) < BITMAP_WORDS))
        else $error("scan address past the last bitmap word");
`endif

endmodule
`default_nettype wire

FILE: bench/block_bitmap_allocator_tb.sv
// ============================================================================
// block_bitmap_allocator_tb
// Self-checking bench for the first-fit block allocator: a directed table of
// allocate/free commands, then random phases that fill the bitmap to full
// and reuse it. Each response is checked against the table or a bitmap model.
// ============================================================================
module block_bitmap_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    typedef struct {
        logic                cmd;
        logic [ID_W-1:0]     id;
        bit                  typed;
        logic [ID_W-1:0]     grant;
        logic [STATUS_W-1:0] status;
    } cmd_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    bba_req_t request = '0;
    logic     done;
    bba_rsp_t response;

    logic [NUM_BLOCKS-1:0] used_map;
    bba_rsp_t              awaited_rsp[$];
    int                    fails = 0;
    cmd_row_t              cmd_table[0:23];

    block_bitmap_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Updates the block map and returns the response the command earns.
    function automatic bba_rsp_t apply_command(input bba_req_t r);
        bba_rsp_t rsp;
        rsp.granted_id = '0;
        rsp.status     = STATUS_OK;
        if (r.command == CMD_ALLOC)
        begin
            rsp.status = STATUS_FULL;
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                if (!used_map[i] && rsp.status == STATUS_FULL)
                begin
                    used_map[i]    = 1'b1;
                    rsp.granted_id = ID_W'(i + 1);
                    rsp.status     = STATUS_OK;
                end
            end
        end
        else if (r.target_id == 0 || int'(r.target_id) > NUM_BLOCKS)
        begin
            rsp.status = STATUS_RANGE;
        end
        else
        begin
            used_map[r.target_id - 1] = 1'b0;
        end
        return rsp;
    endfunction

    function automatic logic [ID_W-1:0] pick_free_id();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            return ID_W'($urandom_range(NUM_BLOCKS, 1));
        end
        else if (sel < 80)
        begin
            return ID_W'($urandom_range(2047, NUM_BLOCKS + 1));
        end
        else if (sel < 85)
        begin
            return '0;
        end
        return ID_W'($urandom_range(2047));
    endfunction

    // Holds start low for random idle cycles, then presents the command until
    // it is taken. busy is read before the edge updates take effect.
    task automatic issue(input bba_req_t r, input int idle_pct, input bit typed,
                         input bba_rsp_t typed_rsp);
        bba_rsp_t pred;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pred = apply_command(r);
        if (typed)
        begin
            pred = typed_rsp;
        end
        awaited_rsp = {awaited_rsp, pred};
    endtask

    task automatic drain();
        start <= 1'b0;
        while (awaited_rsp.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        bba_rsp_t want;
        if (rst_n && done)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $error("response with no transaction outstanding: granted_id %0d status %0d",
                       response.granted_id, response.status);
                fails++;
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (response.granted_id !== want.granted_id)
                begin
                    $error("granted_id: expected %0d, got %0d",
                           want.granted_id, response.granted_id);
                    fails++;
                end
                if (response.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, response.status);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        bba_req_t r;
        bba_rsp_t e;
        int       n_items[4];
        int       idle_pct[4];
        int       alloc_pct[4];

        used_map = '0;
        for (int i = 0; i < RESERVED_CLAMP; i++)
        begin
            used_map[i] = 1'b1;
        end

        cmd_table = '{
            '{CMD_ALLOC, 11'd0,    1'b1, 11'd65, STATUS_OK},
            '{CMD_ALLOC, 11'd2047, 1'b1, 11'd66, STATUS_OK},
            '{CMD_FREE,  11'd0,    1'b1, 11'd0,  STATUS_RANGE},
            '{CMD_FREE,  11'd1025, 1'b1, 11'd0,  STATUS_RANGE},
            '{CMD_FREE,  11'd2047, 1'b1, 11'd0,  STATUS_RANGE},
            '{CMD_FREE,  11'd1024, 1'b1, 11'd0,  STATUS_OK},
            '{CMD_FREE,  11'd1,    1'b1, 11'd0,  STATUS_OK},
            '{CMD_ALLOC, 11'd0,    1'b1, 11'd1,  STATUS_OK},
            '{CMD_FREE,  11'd65,   1'b1, 11'd0,  STATUS_OK},
            '{CMD_FREE,  11'd66,   1'b1, 11'd0,  STATUS_OK},
            '{CMD_FREE,  11'd64,   1'b1, 11'd0,  STATUS_OK},
            '{CMD_FREE,  11'd32,   1'b1, 11'd0,  STATUS_OK},
            '{CMD_FREE,  11'd33,   1'b1, 11'd0,  STATUS_OK},
            '{CMD_ALLOC, 11'd0,    1'b1, 11'd32, STATUS_OK},
            '{CMD_ALLOC, 11'd0,    1'b1, 11'd33, STATUS_OK},
            '{CMD_ALLOC, 11'd0,    1'b1, 11'd64, STATUS_OK},
            '{CMD_ALLOC, 11'd0,    1'b1, 11'd65, STATUS_OK},
            '{CMD_ALLOC, 11'd0,    1'b1, 11'd66, STATUS_OK},
            '{CMD_ALLOC, 11'd0,    1'b1, 11'd67, STATUS_OK},
            '{CMD_FREE,  11'd1023, 1'b1, 11'd0,  STATUS_OK},
            '{CMD_FREE,  11'd512,  1'b0, 11'd0,  STATUS_OK},
            '{CMD_ALLOC, 11'd1365, 1'b0, 11'd0,  STATUS_OK},
            '{CMD_FREE,  11'd66,   1'b0, 11'd0,  STATUS_OK},
            '{CMD_ALLOC, 11'd0,    1'b0, 11'd0,  STATUS_OK}
        };

        // fill phases push the bitmap to full; later phases free and reuse
        n_items   = '{550, 450, 350, 300};
        idle_pct  = '{0, 54, 0, 19};
        alloc_pct = '{99, 99, 35, 65};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (cmd_table[k])
        begin
            r.command    = cmd_table[k].cmd;
            r.target_id  = cmd_table[k].id;
            e.granted_id = cmd_table[k].grant;
            e.status     = cmd_table[k].status;
            issue(r, 0, cmd_table[k].typed, e);
        end
        drain();

        for (int p = 0; p < 4; p++)
        begin
            for (int n = 0; n < n_items[p]; n++)
            begin
                if ($urandom_range(99) < alloc_pct[p])
                begin
                    r.command   = CMD_ALLOC;
                    r.target_id = ID_W'($urandom_range(2047));
                end
                else
                begin
                    r.command   = CMD_FREE;
                    r.target_id = pick_free_id();
                end
                issue(r, idle_pct[p], 1'b0, '0);
            end
            drain();
        end

        repeat (BITMAP_WORDS + 8) @(posedge clk);
        if (awaited_rsp.size() != 0)
        begin
            $error("%0d responses never arrived", awaited_rsp.size());
            fails++;
        end
        if (fails == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: block_bitmap_allocator.f
rtl/core/bba_pkg.sv
rtl/core/block_bitmap_allocator.sv
bench/block_bitmap_allocator_tb.sv
